// ===== src/pac_pkg.sv =====
`default_nettype none
package pac_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MAX_VERTICES = 4096;
	localparam int CNT_W        = 13;
	localparam int AREA_W       = 45;
	localparam int MOM_W        = 62;
	localparam int CROSS_W      = 2 * COORD_BITS + 1;
	localparam int SUM_W        = COORD_BITS + 1;
	localparam int PROD_W       = SUM_W + CROSS_W;
	localparam int QUO_W        = COORD_BITS + 1;
	localparam int TDATA_W      = 80;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
		logic signed [COORD_BITS-1:0] qx;
		logic signed [COORD_BITS-1:0] qy;
	} edge_t;

endpackage
`default_nettype wire

// ===== src/pac_edge_unit.sv =====
`default_nettype none
module pac_edge_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire pac_pkg::edge_t                op,
	input  wire logic                          clear,
	output logic                               done,
	output logic signed [pac_pkg::AREA_W-1:0]  cross_sum,
	output logic signed [pac_pkg::MOM_W-1:0]   moment_x_sum,
	output logic signed [pac_pkg::MOM_W-1:0]   moment_y_sum
);
	import pac_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE, E_P0, E_P1, E_C, E_MX, E_MY, E_FIN
	} estate_t;

	estate_t                      state_q;
	edge_t                        op_q;
	logic signed [SUM_W-1:0]      mul_a;
	logic signed [CROSS_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]     product;
	logic signed [PROD_W-1:0]     prod_q;
	logic signed [2*COORD_BITS-1:0] t_q;
	logic signed [CROSS_W-1:0]    c_q;
	logic signed [CROSS_W-1:0]    c_new;
	logic signed [AREA_W-1:0]     cross_q;
	logic signed [MOM_W-1:0]      mx_q;
	logic signed [MOM_W-1:0]      my_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			E_P0: begin
				mul_a = SUM_W'(op_q.px);
				mul_b = CROSS_W'(op_q.qy);
			end
			E_P1: begin
				mul_a = SUM_W'(op_q.py);
				mul_b = CROSS_W'(op_q.qx);
			end
			E_MX: begin
				mul_a = SUM_W'(op_q.px) + SUM_W'(op_q.qx);
				mul_b = c_q;
			end
			E_MY: begin
				mul_a = SUM_W'(op_q.py) + SUM_W'(op_q.qy);
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign product = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign c_new   = CROSS_W'(t_q) - CROSS_W'($signed(prod_q[2*COORD_BITS-1:0]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cross_q <= '0;
			mx_q    <= '0;
			my_q    <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (start) begin
						state_q <= E_P0;
					end
				end
				E_P0: state_q <= E_P1;
				E_P1: state_q <= E_C;
				E_C: begin
					cross_q <= cross_q + AREA_W'(c_new);
					state_q <= E_MX;
				end
				E_MX: state_q <= E_MY;
				E_MY: begin
					mx_q    <= mx_q + MOM_W'(prod_q);
					state_q <= E_FIN;
				end
				E_FIN: begin
					my_q    <= my_q + MOM_W'(prod_q);
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
			if (clear) begin
				cross_q <= '0;
				mx_q    <= '0;
				my_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			op_q <= op;
		end
		if (state_q == E_P1) begin
			t_q <= prod_q[2*COORD_BITS-1:0];
		end
		if (state_q == E_C) begin
			c_q <= c_new;
		end
		prod_q <= product;
	end

	assign done         = (state_q == E_FIN);
	assign cross_sum    = cross_q;
	assign moment_x_sum = mx_q;
	assign moment_y_sum = my_q;

endmodule
`default_nettype wire

// ===== src/pac_divider.sv =====
`default_nettype none
module pac_divider (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [pac_pkg::MOM_W-1:0]     num,
	input  wire logic signed [pac_pkg::AREA_W-1:0]    area,
	output logic                                      done,
	output logic signed [pac_pkg::COORD_BITS-1:0]     quotient
);
	import pac_pkg::*;

	localparam int NMAG_W = MOM_W;
	localparam int D3_W   = AREA_W + 2;
	localparam int DEN_W  = D3_W + 1;
	localparam int REM_W  = NMAG_W + 2;
	localparam int K_W    = $clog2(QUO_W);
	localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((1 << (COORD_BITS - 1)) - 1);
	localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1 << (COORD_BITS - 1));

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dstate_t;

	dstate_t              state_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     ds_q;
	logic [QUO_W-1:0]     q_q;
	logic [K_W-1:0]       k_q;
	logic                 neg_q;
	logic                 sat_q;

	logic [AREA_W-1:0]    a_mag;
	logic [NMAG_W-1:0]    n_mag;
	logic [D3_W-1:0]      d3;
	logic [DEN_W-1:0]     den2;
	logic [REM_W-1:0]     n_init;
	logic                 sat_init;
	logic                 ge;

	assign a_mag    = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
	assign n_mag    = num[MOM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
	assign d3       = {a_mag, 1'b0} + D3_W'(a_mag);
	assign den2     = {d3, 1'b0};
	assign n_init   = {n_mag, 1'b0} + REM_W'(d3);
	assign sat_init = {1'b0, n_init} >= {den2, (QUO_W)'(0)};
	assign ge       = rem_q >= ds_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (k_q == '0) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q <= n_init;
			ds_q  <= {den2, (QUO_W-1)'(0)};
			q_q   <= '0;
			k_q   <= K_W'(QUO_W - 1);
			neg_q <= num[MOM_W-1] ^ area[AREA_W-1];
			sat_q <= sat_init;
		end else if (state_q == D_RUN) begin
			if (ge) begin
				rem_q <= rem_q - ds_q;
			end
			q_q  <= {q_q[QUO_W-2:0], ge};
			ds_q <= ds_q >> 1;
			k_q  <= k_q - K_W'(1);
		end
	end

	always_comb begin
		if (neg_q) begin
			if (sat_q || q_q > NEG_LIM) begin
				quotient = COORD_BITS'(-NEG_LIM);
			end else begin
				quotient = COORD_BITS'(-q_q);
			end
		end else begin
			if (sat_q || q_q > POS_LIM) begin
				quotient = COORD_BITS'(POS_LIM);
			end else begin
				quotient = COORD_BITS'(q_q);
			end
		end
	end

	assign done = (state_q == D_DONE);

endmodule
`default_nettype wire

// ===== src/polygon_area_centroid_unit.sv =====
`default_nettype none
// Polygon area and centroid unit. Stream the ring's vertices in one beat each
// (x in tdata[15:0], y in tdata[31:16]) and mark the final vertex with tlast;
// that beat produces one result beat with twice the signed area, the centroid
// rounded half away from zero, and a status in tuser (0 ok, 1 zero area with
// a zero centroid, 2 more than 4096 vertices with all fields zero). One shared
// 17x33 multiplier works each edge, and a vertex is not taken until the last
// one's edge is done. The final vertex adds the closing edge and two 17-step
// restoring divisions; with a nonzero area the result beat appears after both
// divisions, when input ready returns as well.
// A finished result waits in the output register while the next ring is taken.
module polygon_area_centroid_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // vertex_x[15:0], vertex_y[31:16]
	input  wire logic        s_tlast,   // last_vertex
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // twice_signed_area[44:0], centroid_x[60:45],
	                                    // centroid_y[76:61], zero[79:77]
	output logic [1:0]       m_tuser    // ring_status[1:0]
);
	import pac_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_EDGE, S_CHK, S_CLOSE, S_AREA, S_STX, S_DIVX, S_STY, S_DIVY, S_OUT
	} state_t;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

	state_t                       state_q;
	logic signed [COORD_BITS-1:0] first_x_q;
	logic signed [COORD_BITS-1:0] first_y_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         last_q;
	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic [1:0]                   status_q;
	logic                         m_tvalid_q;
	logic [TDATA_W-1:0]           m_tdata_q;
	logic [1:0]                   m_tuser_q;

	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic                         accept;
	logic                         edge_start;
	logic                         edge_done;
	logic                         acc_clear;
	logic                         out_load;
	edge_t                        edge_op;
	logic signed [AREA_W-1:0]     cross_sum;
	logic signed [MOM_W-1:0]      mx_sum;
	logic signed [MOM_W-1:0]      my_sum;
	logic                         div_start;
	logic                         div_done;
	logic signed [MOM_W-1:0]      div_num;
	logic signed [COORD_BITS-1:0] div_q;
	logic signed [AREA_W-1:0]     area_out;

	assign in_x     = s_tdata[COORD_BITS-1:0];
	assign in_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);
	assign acc_clear = out_load;

	always_comb begin
		if (state_q == S_CHK) begin
			edge_op = '{px: prev_x_q, py: prev_y_q, qx: first_x_q, qy: first_y_q};
		end else begin
			edge_op = '{px: prev_x_q, py: prev_y_q, qx: in_x, qy: in_y};
		end
	end

	assign edge_start = (accept && cnt_q != '0 && cnt_q < CNT_MAX)
		|| (state_q == S_CHK && last_q && cnt_q <= CNT_MAX);
	assign div_start  = (state_q == S_STX) || (state_q == S_STY);
	assign div_num    = (state_q == S_STY) ? my_sum : mx_sum;
	assign area_out   = (status_q == ST_OVF) ? '0 : cross_sum;

	pac_edge_unit u_edge (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (edge_start),
		.op           (edge_op),
		.clear        (acc_clear),
		.done         (edge_done),
		.cross_sum    (cross_sum),
		.moment_x_sum (mx_sum),
		.moment_y_sum (my_sum)
	);

	pac_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.area     (cross_sum),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			last_q     <= 1'b0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			status_q   <= ST_OK;
			cx_q       <= '0;
			cy_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !out_load) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= s_tlast;
						if (cnt_q >= CNT_MAX) begin
							cnt_q   <= CNT_MAX + CNT_W'(1);
							state_q <= S_CHK;
						end else begin
							if (cnt_q == '0) begin
								first_x_q <= in_x;
								first_y_q <= in_y;
								state_q   <= S_CHK;
							end else begin
								state_q <= S_EDGE;
							end
							prev_x_q <= in_x;
							prev_y_q <= in_y;
							cnt_q    <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_EDGE: begin
					if (edge_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (cnt_q > CNT_MAX) begin
						status_q <= ST_OVF;
						cx_q     <= '0;
						cy_q     <= '0;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					if (edge_done) begin
						state_q <= S_AREA;
					end
				end
				S_AREA: begin
					if (cross_sum == '0) begin
						status_q <= ST_ZERO;
						cx_q     <= '0;
						cy_q     <= '0;
						state_q  <= S_OUT;
					end else begin
						status_q <= ST_OK;
						state_q  <= S_STX;
					end
				end
				S_STX: state_q <= S_DIVX;
				S_DIVX: begin
					if (div_done) begin
						cx_q    <= div_q;
						state_q <= S_STY;
					end
				end
				S_STY: state_q <= S_DIVY;
				S_DIVY: begin
					if (div_done) begin
						cy_q    <= div_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						m_tvalid_q <= 1'b1;
						cnt_q      <= '0;
						last_q     <= 1'b0;
						first_x_q  <= '0;
						first_y_q  <= '0;
						prev_x_q   <= '0;
						prev_y_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {(TDATA_W - AREA_W - 2 * COORD_BITS)'(0), cy_q, cx_q, area_out};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

// ===== src/pac_checker.sv =====
`default_nettype none
module pac_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [1:0]  m_tuser
);
	import pac_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OVF |-> m_tdata == '0)
		else $error("overflow result carries nonzero fields");

	a_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_ZERO |-> m_tdata == '0)
		else $error("zero-area result carries nonzero fields");

	a_ok_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OK |-> m_tdata[AREA_W-1:0] != '0)
		else $error("ok result with zero area");

endmodule

bind polygon_area_centroid_unit pac_checker u_pac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pac_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1920;
	localparam int PHASES         = 4;

	typedef struct {
		logic [AREA_W-1:0]     area;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [1:0]            status;
	} ring_result_t;

	class ring_scoreboard;
		longint first_x, first_y, prev_x, prev_y;
		int     vtx_cnt;
		longint cross_acc, mom_x_acc, mom_y_acc;
		ring_result_t expected_rings[$];
		int     mismatches;

		function new();
			mismatches = 0;
			clear_ring();
		endfunction

		function void clear_ring();
			first_x   = 0;
			first_y   = 0;
			prev_x    = 0;
			prev_y    = 0;
			vtx_cnt   = 0;
			cross_acc = 0;
			mom_x_acc = 0;
			mom_y_acc = 0;
		endfunction

		function void accumulate_edge(longint px, longint py, longint qx, longint qy);
			longint c;
			c = px * qy - py * qx;
			cross_acc += c;
			mom_x_acc += (px + qx) * c;
			mom_y_acc += (py + qy) * c;
		endfunction

		function logic [COORD_BITS-1:0] rounded_centroid(longint num, longint den);
			bit                neg;
			longint unsigned   n, d, q;
			longint            r, hi, lo;
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			q = (2 * n + d) / (2 * d);
			if (q > (64'd1 << 20))
				q = 64'd1 << 20;
			r = neg ? -longint'(q) : longint'(q);
			hi = (longint'(1) << (COORD_BITS - 1)) - 1;
			lo = -(longint'(1) << (COORD_BITS - 1));
			if (r > hi)
				r = hi;
			if (r < lo)
				r = lo;
			return r[COORD_BITS-1:0];
		endfunction

		function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, logic last);
			ring_result_t res;
			longint       vx, vy;
			vx = longint'(x);
			vy = longint'(y);
			if (vtx_cnt >= MAX_VERTICES) begin
				vtx_cnt = MAX_VERTICES + 1;
			end else begin
				if (vtx_cnt == 0) begin
					first_x = vx;
					first_y = vy;
				end else begin
					accumulate_edge(prev_x, prev_y, vx, vy);
				end
				prev_x = vx;
				prev_y = vy;
				vtx_cnt++;
			end
			if (!last)
				return;
			res.area   = '0;
			res.cx     = '0;
			res.cy     = '0;
			if (vtx_cnt > MAX_VERTICES) begin
				res.status = ST_OVF;
			end else begin
				accumulate_edge(prev_x, prev_y, first_x, first_y);
				res.area = cross_acc[AREA_W-1:0];
				if (cross_acc == 0) begin
					res.status = ST_ZERO;
				end else begin
					res.status = ST_OK;
					res.cx = rounded_centroid(mom_x_acc, 3 * cross_acc);
					res.cy = rounded_centroid(mom_y_acc, 3 * cross_acc);
				end
			end
			expected_rings = {expected_rings, res};
			clear_ring();
		endfunction

		task report(string msg);
			if (mismatches < 50)
				$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(logic [TDATA_W-1:0] data, logic [1:0] user);
			ring_result_t exp_res;
			if (expected_rings.size() == 0) begin
				report($sformatf("unexpected result beat tdata=%h tuser=%0d", data, user));
				return;
			end
			exp_res = expected_rings.pop_front();
			if (data[44:0] !== exp_res.area)
				report($sformatf("area got %0d exp %0d",
					$signed(data[44:0]), $signed(exp_res.area)));
			if (data[60:45] !== exp_res.cx)
				report($sformatf("centroid_x got %0d exp %0d",
					$signed(data[60:45]), $signed(exp_res.cx)));
			if (data[76:61] !== exp_res.cy)
				report($sformatf("centroid_y got %0d exp %0d",
					$signed(data[76:61]), $signed(exp_res.cy)));
			if (data[79:77] !== 3'b000)
				report($sformatf("pad bits got %b", data[79:77]));
			if (user !== exp_res.status)
				report($sformatf("status got %0d exp %0d", user, exp_res.status));
		endtask

		function int pending();
			return expected_rings.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [31:0]        s_tdata;
	logic               s_tlast;
	logic               m_tvalid;
	logic               m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic [1:0]         m_tuser;

	ring_scoreboard ring_sb;
	int             src_idle_pct;
	int             snk_stall_pct;
	int             vertices_sent;
	int             idle_cycles;

	polygon_area_centroid_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			ring_sb.check_result(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_beat(input logic [15:0] x, input logic [15:0] y, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {y, x};
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		ring_sb.note_vertex(x, y, last);
		vertices_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (ring_sb.pending() != 0);
	endtask

	function automatic logic [15:0] pick_coord(int style);
		case (style)
			0: return 16'($urandom);
			1: return 16'($urandom_range(64) - 32);
			default: begin
				case ($urandom_range(5))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'h0000;
					3: return 16'hFFFF;
					4: return 16'h0001;
					default: return 16'h8001;
				endcase
			end
		endcase
	endfunction

	task automatic send_ring(int n, int style);
		logic [15:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = pick_coord(style == 3 ? 0 : style);
			y = (style == 3) ? x : pick_coord(style);
			send_beat(x, y, i == n - 1);
		end
	endtask

	task automatic send_random_ring();
		int sel, n, style;
		sel = $urandom_range(99);
		style = $urandom_range(2);
		if (sel < 6) begin
			n = $urandom_range(1, 2);
		end else if (sel < 12) begin
			n = $urandom_range(3, 6);
			style = 3;
		end else if (sel < 17) begin
			n = $urandom_range(13, 64);
		end else begin
			n = $urandom_range(3, 12);
		end
		send_ring(n, style);
	endtask

	initial begin
		int target;
		ring_sb       = new();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		vertices_sent = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(16'h8000, 16'h7FFF, 1'b1);

		send_beat(16'd0, 16'd0, 1'b0);
		send_beat(16'd3, 16'd0, 1'b0);
		send_beat(16'd0, 16'd3, 1'b1);

		send_beat(16'h8000, 16'h8000, 1'b0);
		send_beat(16'h7FFF, 16'h7FFF, 1'b0);
		send_beat(16'h7FFF, 16'h8000, 1'b1);

		send_beat(16'd5, 16'd7, 1'b0);
		send_beat(-16'sd9, 16'd2, 1'b1);

		send_beat(-16'sd4, -16'sd4, 1'b0);
		send_beat(16'd1, 16'd1, 1'b0);
		send_beat(16'd9, 16'd9, 1'b1);

		send_beat(16'd0, 16'd0, 1'b0);
		send_beat(16'd20000, 16'd20000, 1'b0);
		send_beat(16'd20000, 16'd0, 1'b0);
		send_beat(16'd0, 16'd20001, 1'b1);

		send_beat(16'd0, 16'd0, 1'b0);
		send_beat(-16'sd20000, -16'sd20000, 1'b0);
		send_beat(-16'sd20000, 16'd0, 1'b0);
		send_beat(16'd0, -16'sd20001, 1'b1);

		send_beat(16'd0, 16'd0, 1'b0);
		send_beat(16'd1, 16'd0, 1'b0);
		send_beat(16'd1, 16'd1, 1'b0);
		send_beat(16'd0, 16'd1, 1'b1);

		send_beat(16'd0, 16'd0, 1'b0);
		send_beat(-16'sd1, 16'd0, 1'b0);
		send_beat(-16'sd1, -16'sd1, 1'b0);
		send_beat(16'd0, -16'sd1, 1'b1);

		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct  = 86;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct  = 0;
					snk_stall_pct = 86;
				end
				default: begin
					src_idle_pct  = 17;
					snk_stall_pct = 17;
				end
			endcase
			target = vertices_sent + RANDOM_ITEMS / PHASES;
			while (vertices_sent < target)
				send_random_ring();
			wait_drained();
		end

		repeat (100) @(posedge clk);
		if (ring_sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pac_pkg.sv
src/pac_edge_unit.sv
src/pac_divider.sv
src/polygon_area_centroid_unit.sv
src/pac_checker.sv
dv/tb.sv
